/* rtl/ac3md_pkg.sv */
// ----------------------------------------------------------------------------
// ac3md_pkg
// Shared types, codes, quantizer tables and small constant dividers for the
// AC-3 mantissa ungrouping and dequantization block.
// ----------------------------------------------------------------------------
package ac3md_pkg;

	localparam int unsigned QueueDepth = 2;

	localparam int unsigned BapW    = 4;
	localparam int unsigned WinW    = 16;
	localparam int unsigned MantW   = 16;
	localparam int unsigned UsedW   = 5;
	localparam int unsigned LvlW    = 4;
	localparam int unsigned NumLvl  = 3;

	localparam logic CMD_DECODE = 1'b0;
	localparam logic CMD_CLEAR  = 1'b1;

	localparam logic [BapW-1:0] BAP_ZERO = 4'd0;
	localparam logic [BapW-1:0] BAP_T3   = 4'd1;
	localparam logic [BapW-1:0] BAP_T5   = 4'd2;
	localparam logic [BapW-1:0] BAP_Q7   = 4'd3;
	localparam logic [BapW-1:0] BAP_P11  = 4'd4;
	localparam logic [BapW-1:0] BAP_Q15  = 4'd5;

	localparam logic [UsedW-1:0] USED_T3  = 5'd5;
	localparam logic [UsedW-1:0] USED_T5  = 5'd7;
	localparam logic [UsedW-1:0] USED_Q7  = 5'd3;
	localparam logic [UsedW-1:0] USED_P11 = 5'd7;
	localparam logic [UsedW-1:0] USED_Q15 = 5'd4;

	localparam logic [UsedW-1:0] BITS_FOR_BAP [16] = '{
		5'd0, 5'd0, 5'd0, 5'd3, 5'd0, 5'd4, 5'd5, 5'd6,
		5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd14, 5'd16
	};

	localparam logic signed [MantW-1:0] LV3 [3] = '{
		-16'sd21845, 16'sd0, 16'sd21845
	};
	localparam logic signed [MantW-1:0] LV5 [5] = '{
		-16'sd26214, -16'sd13107, 16'sd0, 16'sd13107, 16'sd26214
	};
	localparam logic signed [MantW-1:0] LV7 [7] = '{
		-16'sd28086, -16'sd18724, -16'sd9362, 16'sd0,
		16'sd9362, 16'sd18724, 16'sd28086
	};
	localparam logic signed [MantW-1:0] LV11 [11] = '{
		-16'sd29789, -16'sd23831, -16'sd17873, -16'sd11915, -16'sd5957, 16'sd0,
		16'sd5957, 16'sd11915, 16'sd17873, 16'sd23831, 16'sd29789
	};
	localparam logic signed [MantW-1:0] LV15 [15] = '{
		-16'sd30583, -16'sd26214, -16'sd21845, -16'sd17476, -16'sd13107,
		-16'sd8738, -16'sd4369, 16'sd0, 16'sd4369, 16'sd8738,
		16'sd13107, 16'sd17476, 16'sd21845, 16'sd26214, 16'sd30583
	};

	typedef enum logic [2:0] {
		KIND_CLEAR,
		KIND_ZERO,
		KIND_T3,
		KIND_T5,
		KIND_P11,
		KIND_DIRECT
	} kind_t;

	typedef struct packed {
		kind_t                         kind;
		logic signed [MantW-1:0]       mant;
		logic [UsedW-1:0]              used;
		logic                          bad;
		logic [NumLvl-1:0][LvlW-1:0]   lvl;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} qstat_t;

	typedef struct packed {
		logic [3:0] quo;
		logic [6:0] rem;
	} divres_t;

	// restoring divide of a 7-bit value, quotient up to 4 bits
	function automatic divres_t div_small(input logic [6:0] num, input logic [6:0] den);
		divres_t     r;
		logic [10:0] acc;
		logic [10:0] sub;
		acc   = {4'b0, num};
		r.quo = '0;
		for (int s = 3; s >= 0; s--) begin
			sub = {4'b0, den} << s;
			if (acc >= sub) begin
				acc      = acc - sub;
				r.quo[s] = 1'b1;
			end
		end
		r.rem = acc[6:0];
		return r;
	endfunction

endpackage

/* rtl/ac3md_if.sv */
// ----------------------------------------------------------------------------
// ac3md_if
// Valid/ready channels for mantissa requests and dequantized results.
// ----------------------------------------------------------------------------
interface ac3md_req_if;
	logic                              valid;
	logic                              ready;
	logic                              command;
	logic [ac3md_pkg::BapW-1:0]        bit_alloc;
	logic [ac3md_pkg::WinW-1:0]        bits_window;

	modport source (output valid, output command, output bit_alloc, output bits_window,
		input ready);
	modport sink (input valid, input command, input bit_alloc, input bits_window,
		output ready);
endinterface

interface ac3md_res_if;
	logic                              valid;
	logic                              ready;
	logic signed [ac3md_pkg::MantW-1:0] mantissa;
	logic [ac3md_pkg::UsedW-1:0]       bits_used;
	logic                              invalid_code;

	modport source (output valid, output mantissa, output bits_used, output invalid_code,
		input ready);
	modport sink (input valid, input mantissa, input bits_used, input invalid_code,
		output ready);
endinterface

/* rtl/ac3md_front.sv */
// ----------------------------------------------------------------------------
// ac3md_front
// Request intake: splits group codes into levels and resolves the
// stateless quantizer classes.
// ----------------------------------------------------------------------------
module ac3md_front (
	ac3md_req_if.sink          req,
	input  ac3md_pkg::qstat_t  qstat,
	output logic               push,
	output ac3md_pkg::item_t   item
);

	logic [ac3md_pkg::WinW-1:0] win;
	logic [4:0]                 code5;
	logic [6:0]                 code7;
	logic [2:0]                 q3;
	logic [3:0]                 q4;
	logic [ac3md_pkg::UsedW-1:0] n;
	ac3md_pkg::divres_t         d9, d3, d25, d5, d11;

	assign req.ready = !qstat.full;
	assign push      = req.valid && !qstat.full;

	assign win   = req.bits_window;
	assign code5 = win[15:11];
	assign code7 = win[15:9];
	assign q3    = win[15:13];
	assign q4    = win[15:12];
	assign n     = ac3md_pkg::BITS_FOR_BAP[req.bit_alloc];

	assign d9  = ac3md_pkg::div_small({2'b0, code5}, 7'd9);
	assign d3  = ac3md_pkg::div_small(d9.rem, 7'd3);
	assign d25 = ac3md_pkg::div_small(code7, 7'd25);
	assign d5  = ac3md_pkg::div_small(d25.rem, 7'd5);
	assign d11 = ac3md_pkg::div_small(code7, 7'd11);

	always_comb begin
		item.kind = ac3md_pkg::KIND_ZERO;
		item.mant = '0;
		item.used = '0;
		item.bad  = 1'b0;
		item.lvl  = '0;
		if (req.command == ac3md_pkg::CMD_CLEAR) begin
			item.kind = ac3md_pkg::KIND_CLEAR;
		end else begin
			case (req.bit_alloc)
				ac3md_pkg::BAP_ZERO: begin
					item.kind = ac3md_pkg::KIND_ZERO;
				end
				ac3md_pkg::BAP_T3: begin
					item.kind   = ac3md_pkg::KIND_T3;
					item.lvl[0] = {2'b0, d9.quo[1:0]};
					item.lvl[1] = d3.quo;
					item.lvl[2] = d3.rem[3:0];
				end
				ac3md_pkg::BAP_T5: begin
					item.kind   = ac3md_pkg::KIND_T5;
					item.lvl[0] = {1'b0, d25.quo[2:0]};
					item.lvl[1] = d5.quo;
					item.lvl[2] = d5.rem[3:0];
				end
				ac3md_pkg::BAP_P11: begin
					item.kind   = ac3md_pkg::KIND_P11;
					item.lvl[0] = d11.quo;
					item.lvl[1] = d11.rem[3:0];
				end
				ac3md_pkg::BAP_Q7: begin
					item.kind = ac3md_pkg::KIND_DIRECT;
					item.used = ac3md_pkg::USED_Q7;
					if (q3 == 3'd7) begin
						item.bad = 1'b1;
					end else begin
						item.mant = ac3md_pkg::LV7[q3];
					end
				end
				ac3md_pkg::BAP_Q15: begin
					item.kind = ac3md_pkg::KIND_DIRECT;
					item.used = ac3md_pkg::USED_Q15;
					if (q4 == 4'd15) begin
						item.bad = 1'b1;
					end else begin
						item.mant = ac3md_pkg::LV15[q4];
					end
				end
				default: begin
					item.kind = ac3md_pkg::KIND_DIRECT;
					item.used = n;
					item.mant = signed'(win & ~(16'hFFFF >> n));
				end
			endcase
		end
	end

endmodule

/* rtl/ac3md_queue.sv */
// ----------------------------------------------------------------------------
// ac3md_queue
// Small register queue between request intake and the group engine.
// ----------------------------------------------------------------------------
module ac3md_queue #(
	parameter int unsigned Depth = ac3md_pkg::QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  ac3md_pkg::item_t   wdata,
	input  logic               pop,
	output ac3md_pkg::item_t   rdata,
	output ac3md_pkg::qstat_t  stat
);

	localparam int unsigned PtrW = $clog2(Depth);
	localparam int unsigned CntW = $clog2(Depth + 1);

	ac3md_pkg::item_t  mem_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign stat.full  = count_q == CntW'(Depth);
	assign stat.empty = count_q == '0;
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* rtl/ac3md_back.sv */
// ----------------------------------------------------------------------------
// ac3md_back
// Group engine: keeps the grouped levels, hands out one level per item,
// dequantizes it and holds the result in the output register.
// ----------------------------------------------------------------------------
module ac3md_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ac3md_pkg::item_t   item,
	input  logic               avail,
	output logic               pop,
	ac3md_res_if.source        res
);

	localparam logic [1:0] NEXT_EMPTY = 2'd3;

	logic [1:0] t3_lvl_q [3];
	logic [2:0] t5_lvl_q [3];
	logic [3:0] p11_lvl_q [2];
	logic [1:0] t3_next_q, t5_next_q, p11_next_q;

	logic                             out_valid_q;
	logic signed [ac3md_pkg::MantW-1:0] mant_q;
	logic [ac3md_pkg::UsedW-1:0]      used_q;
	logic                             bad_q;

	logic                             t3_fill, t5_fill, p11_fill;
	logic [ac3md_pkg::LvlW-1:0]       lvl_sel;
	logic signed [ac3md_pkg::MantW-1:0] mant_d;
	logic [ac3md_pkg::UsedW-1:0]      used_d;
	logic                             bad_d;

	assign pop = avail && (!out_valid_q || res.ready);

	assign t3_fill  = t3_next_q > 2'd2;
	assign t5_fill  = t5_next_q > 2'd2;
	assign p11_fill = p11_next_q > 2'd1;

	always_comb begin
		lvl_sel = '0;
		mant_d  = '0;
		used_d  = '0;
		bad_d   = 1'b0;
		case (item.kind)
			ac3md_pkg::KIND_T3: begin
				if (t3_fill) begin
					lvl_sel = item.lvl[0];
					used_d  = ac3md_pkg::USED_T3;
				end else begin
					lvl_sel = {2'b0, t3_lvl_q[t3_next_q]};
				end
				if (lvl_sel >= 4'd3) begin
					bad_d = 1'b1;
				end else begin
					mant_d = ac3md_pkg::LV3[lvl_sel[1:0]];
				end
			end
			ac3md_pkg::KIND_T5: begin
				if (t5_fill) begin
					lvl_sel = item.lvl[0];
					used_d  = ac3md_pkg::USED_T5;
				end else begin
					lvl_sel = {1'b0, t5_lvl_q[t5_next_q]};
				end
				if (lvl_sel >= 4'd5) begin
					bad_d = 1'b1;
				end else begin
					mant_d = ac3md_pkg::LV5[lvl_sel[2:0]];
				end
			end
			ac3md_pkg::KIND_P11: begin
				if (p11_fill) begin
					lvl_sel = item.lvl[0];
					used_d  = ac3md_pkg::USED_P11;
				end else begin
					lvl_sel = p11_lvl_q[p11_next_q[0]];
				end
				if (lvl_sel >= 4'd11) begin
					bad_d = 1'b1;
				end else begin
					mant_d = ac3md_pkg::LV11[lvl_sel];
				end
			end
			ac3md_pkg::KIND_DIRECT: begin
				mant_d = item.mant;
				used_d = item.used;
				bad_d  = item.bad;
			end
			default: begin
				mant_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				t3_lvl_q[i] <= '0;
				t5_lvl_q[i] <= '0;
			end
			p11_lvl_q[0] <= '0;
			p11_lvl_q[1] <= '0;
			t3_next_q    <= NEXT_EMPTY;
			t5_next_q    <= NEXT_EMPTY;
			p11_next_q   <= NEXT_EMPTY;
		end else if (pop) begin
			case (item.kind)
				ac3md_pkg::KIND_CLEAR: begin
					for (int i = 0; i < 3; i++) begin
						t3_lvl_q[i] <= '0;
						t5_lvl_q[i] <= '0;
					end
					p11_lvl_q[0] <= '0;
					p11_lvl_q[1] <= '0;
					t3_next_q    <= NEXT_EMPTY;
					t5_next_q    <= NEXT_EMPTY;
					p11_next_q   <= NEXT_EMPTY;
				end
				ac3md_pkg::KIND_T3: begin
					if (t3_fill) begin
						for (int i = 0; i < 3; i++) begin
							t3_lvl_q[i] <= item.lvl[i][1:0];
						end
						t3_next_q <= 2'd1;
					end else begin
						t3_next_q <= t3_next_q + 2'd1;
					end
				end
				ac3md_pkg::KIND_T5: begin
					if (t5_fill) begin
						for (int i = 0; i < 3; i++) begin
							t5_lvl_q[i] <= item.lvl[i][2:0];
						end
						t5_next_q <= 2'd1;
					end else begin
						t5_next_q <= t5_next_q + 2'd1;
					end
				end
				ac3md_pkg::KIND_P11: begin
					if (p11_fill) begin
						p11_lvl_q[0] <= item.lvl[0];
						p11_lvl_q[1] <= item.lvl[1];
						p11_next_q   <= 2'd1;
					end else begin
						p11_next_q <= p11_next_q + 2'd1;
					end
				end
				default: begin
					t3_next_q <= t3_next_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mant_q <= mant_d;
			used_q <= used_d;
			bad_q  <= bad_d;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.mantissa     = mant_q;
	assign res.bits_used    = used_q;
	assign res.invalid_code = bad_q;

endmodule

/* rtl/ac3_mantissa_ungroup_dequant_top.sv */
// ----------------------------------------------------------------------------
// ac3_mantissa_ungroup_dequant_top
// AC-3 mantissa ungrouping and dequantization, one result per request.
//
//   channel  dir  payload                              handshake
//   req      in   command, bit_alloc, bits_window      valid/ready
//   res      out  mantissa, bits_used, invalid_code    valid/ready
//
// One item per cycle sustained while res accepts; the result is registered in
// the queue entry, then in the group engine's output register.
// The rate is set by the group engine, which updates its level stores
// once per item. Reset empties all group stores and the queue.
// req stalls only when the queue is full; res backpressure fills the queue.
// ----------------------------------------------------------------------------
module ac3_mantissa_ungroup_dequant_top #(
	parameter int unsigned QueueDepth = ac3md_pkg::QueueDepth
) (
	input logic         clk,
	input logic         arst_n,
	ac3md_req_if.sink   req,
	ac3md_res_if.source res
);

	ac3md_pkg::qstat_t qstat;
	ac3md_pkg::item_t  front_item, head_item;
	logic              push, pop;

	ac3md_front u_front (
		.req   (req),
		.qstat (qstat),
		.push  (push),
		.item  (front_item)
	);

	ac3md_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_item),
		.pop    (pop),
		.rdata  (head_item),
		.stat   (qstat)
	);

	ac3md_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (head_item),
		.avail  (!qstat.empty),
		.pop    (pop),
		.res    (res)
	);

`ifndef SYNTHESIS
	a_bad_gives_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.invalid_code |-> res.mantissa == '0)
		else $error("invalid item with nonzero mantissa");

	a_bad_bit_count: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.invalid_code |->
			res.bits_used == 5'd0 || res.bits_used == 5'd3 || res.bits_used == 5'd4 ||
			res.bits_used == 5'd5 || res.bits_used == 5'd7)
		else $error("invalid item from a class without range check");

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.bits_used <= 5'd16)
		else $error("bits_used out of range");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		!qstat.empty && (!res.valid || res.ready) |=> res.valid)
		else $error("queued item not moved to output");
`endif

endmodule
